### rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and controller/datapath interface types for the
// population standard deviation block.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;

    // port widths of the payload fields
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 24;

    // derived datapath widths
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int SQ_W    = 2 * SAMPLE_BITS + CNT_W - 2;
    localparam int D_W     = SQ_W + CNT_W;
    localparam int RAD_W   = ((D_W + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int ITER_MAX = (ROOT_W > CNT_W) ? ROOT_W : CNT_W;
    localparam int STEP_W  = $clog2(ITER_MAX);
    localparam int SAT_W   = ((ROOT_W > OUT_W) ? ROOT_W : OUT_W) + 1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic drain;
        logic mul_step;
        logic sub;
        logic root_step;
        logic div_step;
        logic finish;
    } psd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_fire;
        logic out_free;
    } psd_status_t;

endpackage

### rtl/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer: accumulates samples, then steps the datapath through the
// multiply, subtract, square root and divide of the final result.
// ----------------------------------------------------------------------------
module psd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  psd_pkg::psd_status_t status,
    output psd_pkg::psd_cmd_t    cmd
);
    import psd_pkg::*;

    typedef enum logic [6:0] {
        ST_ACC   = 7'b0000001,
        ST_DRAIN = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_SUB   = 7'b0001000,
        ST_ROOT  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_ACC:
            begin
                cmd.accept = 1'b1;
                if (status.last_fire)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.drain  = 1'b1;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (step_reg == STEP_W'(CNT_W - 1))
                begin
                    state_next = ST_SUB;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/psd_datapath.sv
// ----------------------------------------------------------------------------
// psd_datapath
// Accumulators, bit-serial multiply by count, digit-by-digit square root,
// restoring divide and the output register.
// ----------------------------------------------------------------------------
module psd_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  psd_pkg::psd_cmd_t      cmd,
    output psd_pkg::psd_status_t   status,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [psd_pkg::SAMPLE_W-1:0] s_tdata,  // [15:0] sample
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [psd_pkg::OUT_W-1:0] m_tdata,     // [23:0] std_dev
    output logic                   m_tuser         // [0] overflowed
);
    import psd_pkg::*;

    // accumulation
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]           sumsq_reg, sumsq_next;
    logic                      drop_reg, drop_next;
    logic [2*SAMPLE_BITS-1:0]  p_sq_reg, p_sq_next;
    logic                      p_vld_reg, p_vld_next;

    // final computation
    logic [D_W-1:0]            sq_reg, sq_next;
    logic [D_W-1:0]            a_reg, a_next;
    logic [CNT_W-1:0]          m_reg, m_next;
    logic [D_W-1:0]            prod_reg, prod_next;
    logic [RAD_W-1:0]          rad_reg, rad_next;
    logic [ROOT_W-1:0]         root_reg, root_next;
    logic [ROOT_W+1:0]         rrem_reg, rrem_next;
    logic [CNT_W-1:0]          drem_reg, drem_next;

    // output register
    logic [OUT_W-1:0]          out_std_reg, out_std_next;
    logic                      out_ovf_reg, out_ovf_next;
    logic                      out_vld_reg, out_vld_next;

    logic                      sample_fire;
    logic                      take;
    logic signed [SUM_W-1:0]   v_ext;
    logic [SAMPLE_BITS-1:0]    mag;
    logic [SQ_W-1:0]           sumsq_sum;
    logic [SUM_W-1:0]          smag;
    logic [2*SUM_W-1:0]        smag_prod;
    logic [D_W-1:0]            d_val;
    logic [ROOT_W+1:0]         rem_trial;
    logic [ROOT_W+1:0]         root_trial;
    logic                      root_ge;
    logic [CNT_W:0]            div_trial;
    logic [CNT_W:0]            n_ext;
    logic                      div_ge;
    logic [SAT_W-1:0]          q_ext;

    assign s_tready = cmd.accept;
    assign sample_fire = s_tvalid && cmd.accept;
    assign status.last_fire = sample_fire && s_tlast;
    assign status.out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_std_reg;
    assign m_tuser  = out_ovf_reg;

    always_comb
    begin
        // low SAMPLE_BITS bits of the sample, sign extended
        v_ext = signed'({{(SUM_W - SAMPLE_BITS){s_tdata[SAMPLE_BITS-1]}},
                         s_tdata[SAMPLE_BITS-1:0]});
        mag   = s_tdata[SAMPLE_BITS-1] ? (~s_tdata[SAMPLE_BITS-1:0] + 1'b1)
                                       : s_tdata[SAMPLE_BITS-1:0];
        take  = count_reg < CNT_W'(MAX_SAMPLES);
        sumsq_sum = sumsq_reg + (p_vld_reg ? SQ_W'(p_sq_reg) : '0);

        smag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        smag_prod = smag * smag;

        d_val = (prod_reg >= sq_reg) ? (prod_reg - sq_reg) : '0;

        rem_trial  = {rrem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        root_trial = {root_reg, 2'b01};
        root_ge    = rem_trial >= root_trial;

        div_trial = {drem_reg, root_reg[ROOT_W-1]};
        n_ext     = {1'b0, count_reg};
        div_ge    = div_trial >= n_ext;

        q_ext = SAT_W'(root_reg);

        count_next   = count_reg;
        sum_next     = sum_reg;
        sumsq_next   = sumsq_sum;
        drop_next    = drop_reg;
        p_sq_next    = p_sq_reg;
        p_vld_next   = 1'b0;
        sq_next      = sq_reg;
        a_next       = a_reg;
        m_next       = m_reg;
        prod_next    = prod_reg;
        rad_next     = rad_reg;
        root_next    = root_reg;
        rrem_next    = rrem_reg;
        drem_next    = drem_reg;
        out_std_next = out_std_reg;
        out_ovf_next = out_ovf_reg;
        out_vld_next = m_tready ? 1'b0 : out_vld_reg;

        if (sample_fire)
        begin
            if (take)
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + v_ext;
                p_sq_next  = mag * mag;
                p_vld_next = 1'b1;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        if (cmd.drain)
        begin
            // square of the last sample lands in sumsq this cycle
            sq_next   = smag_prod[D_W-1:0];
            a_next    = D_W'(sumsq_sum);
            m_next    = count_reg;
            prod_next = '0;
        end

        if (cmd.mul_step)
        begin
            if (m_reg[0])
            begin
                prod_next = prod_reg + a_reg;
            end
            a_next = a_reg << 1;
            m_next = m_reg >> 1;
        end

        if (cmd.sub)
        begin
            rad_next  = RAD_W'(d_val) << (2 * FRAC_BITS);
            root_next = '0;
            rrem_next = '0;
            drem_next = '0;
        end

        if (cmd.root_step)
        begin
            rad_next = rad_reg << 2;
            if (root_ge)
            begin
                rrem_next = rem_trial - root_trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rrem_next = rem_trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end

        if (cmd.div_step)
        begin
            // quotient bits shift in where the root bits shift out
            drem_next = div_ge ? CNT_W'(div_trial - n_ext) : div_trial[CNT_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], div_ge};
        end

        if (cmd.finish)
        begin
            priority if (count_reg == '0)
            begin
                out_std_next = '0;
            end
            else if (q_ext > SAT_W'({OUT_W{1'b1}}))
            begin
                out_std_next = '1;
            end
            else
            begin
                out_std_next = q_ext[OUT_W-1:0];
            end
            out_ovf_next = drop_reg;
            out_vld_next = 1'b1;
            count_next   = '0;
            sum_next     = '0;
            sumsq_next   = '0;
            drop_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            drop_reg    <= 1'b0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            sumsq_reg   <= sumsq_next;
            drop_reg    <= drop_next;
            p_vld_reg   <= p_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_sq_reg    <= p_sq_next;
        sq_reg      <= sq_next;
        a_reg       <= a_next;
        m_reg       <= m_next;
        prod_reg    <= prod_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rrem_reg    <= rrem_next;
        drem_reg    <= drem_next;
        out_std_reg <= out_std_next;
        out_ovf_reg <= out_ovf_next;
    end

endmodule

### rtl/population_std_deviation_top.sv
// ----------------------------------------------------------------------------
// population_std_deviation_top
// Population standard deviation of a stream of signed samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a set accumulates; each adds to a
// count, an exact sum and an exact sum of squares. The transaction marked
// tlast closes the set, and input then stays blocked while a bit-serial
// sequence computes the result: a drain step, a shift-and-add multiply of the
// square sum by the count, a subtract, a square root at two radicand bits per
// cycle and a restoring divide by the count, then a finish step that loads the
// output register. The result waits in its own register, so the next set
// starts while it is still pending; a second result waits only if the first
// has not yet been taken. Samples beyond MAX_SAMPLES are dropped and reported
// in m_tuser.
module population_std_deviation_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psd_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psd_pkg::OUT_W-1:0]     m_tdata,   // [23:0] std_dev
    output logic                          m_tuser    // [0] overflowed
);
    import psd_pkg::*;

    psd_cmd_t    cmd;
    psd_status_t status;

    psd_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    psd_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the standard deviation block, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [psd_pkg::SAMPLE_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [psd_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          m_tuser
);
    import psd_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // closing transaction blocks input while the result is computed
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready ##1 !s_tready)
    else $error("input accepted during final computation");

    // a new result shows up just as input reopens
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready && $past(!s_tready))
    else $error("result not aligned with end of computation");

    // a result is never offered before any set has closed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready, 1))
    else $error("result without a closing transaction");

endmodule

bind population_std_deviation_top psd_checker u_psd_checker (.*);
